@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sample feeder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Condition must never hold.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`endif

@@ rtl/core/pdsf_pkg.sv @@
// ----------------------------------------------------------------------------
// Sample feeder package
// Request codes, status codes and fixed field widths of the sample feeder.
// ----------------------------------------------------------------------------
package pdsf_pkg;

    localparam int PCM_W       = 16;
    localparam int BLOCK_W     = 10;
    localparam int STATUS_W    = 2;
    localparam int MODE_W      = 3;
    localparam int CFG_INDEX_W = 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_START = 3'd0,
        MODE_STOP  = 3'd1,
        MODE_WRITE = 3'd2,
        MODE_TICK  = 3'd3,
        MODE_FAULT = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_NOT_STARTED = 2'd1,
        ST_NO_BUFFER   = 2'd2,
        ST_TOO_LONG    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        WP_IDLE    = 2'd0,
        WP_WRITING = 2'd1,
        WP_DISCARD = 2'd2
    } wphase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BLOCK_SAMPLES = 1'd0,
        REG_NOTIFY_ENABLE = 1'd1
    } reg_index_t;

endpackage

@@ rtl/core/pdsf_sample_store.sv @@
// ----------------------------------------------------------------------------
// Sample store
// Two single-port-write buffer halves with a registered read of one half.
// ----------------------------------------------------------------------------
module pdsf_sample_store #(
    parameter int DEPTH  = 512,
    parameter int DATA_W = 12,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic [1:0]        wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic              rd_half,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic              rd_half_reg;

    for (genvar h = 0; h < 2; h++) begin : g_half
        logic [DATA_W-1:0] mem [DEPTH];
        logic [DATA_W-1:0] rd_q_reg;

        always_ff @(posedge aclk) begin
            if (wr_en[h]) begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en && (rd_half == 1'(h))) begin
                rd_q_reg <= mem[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_half_reg <= rd_half;
        end
    end

    assign rd_data = rd_half_reg ? g_half[1].rd_q_reg : g_half[0].rd_q_reg;

endmodule

@@ rtl/core/pingpong_dac_sample_feeder.sv @@
// ----------------------------------------------------------------------------
// Ping-pong DAC sample feeder
// Double-buffered feeder that turns PCM blocks into converter codes.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake            | Payload
//  cfg      | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  s        | in        | s_valid/s_ready      | s_mode, s_pcm_sample, s_last_sample
//  m        | out       | m_valid/m_ready      | m_dac_valid, m_dac_code, m_status,
//           |           |                      | m_block_done, m_underrun, m_request_block
//
//  Stop, fault, start while running, ticks while stopped and sample writes
//  register their result in the cycle after they are accepted.
//  A tick while running passes through S_READ for the registered store read.
//  Start fills both halves with silence up to the block size; a short block write
//  pads the rest of its half with silence; s_ready is low then.
//  Reset is synchronous; the store itself is not cleared.
//  s_ready is low while the result register holds a request and m_ready is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pingpong_dac_sample_feeder #(
    parameter int MAX_BLOCK_SAMPLES = 512,
    parameter int CODE_BITS         = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pdsf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pdsf_pkg::BLOCK_W-1:0]      cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pdsf_pkg::MODE_W-1:0]       s_mode,
    input  logic signed [pdsf_pkg::PCM_W-1:0] s_pcm_sample,
    input  logic                              s_last_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_dac_valid,
    output logic [CODE_BITS-1:0]              m_dac_code,
    output logic [pdsf_pkg::STATUS_W-1:0]     m_status,
    output logic                              m_block_done,
    output logic                              m_underrun,
    output logic                              m_request_block
);

    import pdsf_pkg::*;

    localparam int AW      = (MAX_BLOCK_SAMPLES > 1) ? $clog2(MAX_BLOCK_SAMPLES) : 1;
    localparam int CW      = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam int EFF_RST = (MAX_BLOCK_SAMPLES < 512) ? MAX_BLOCK_SAMPLES : 512;
    localparam logic [CODE_BITS-1:0] SILENCE = {1'b1, {(CODE_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FILL
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     eff_reg, eff_next;
    logic              notify_reg, notify_next;
    logic              active_half_reg, active_half_next;
    logic              running_reg, running_next;
    logic              half_free_reg, half_free_next;
    logic              half_ready_reg, half_ready_next;
    logic [AW-1:0]     play_pos_reg, play_pos_next;
    logic [CW-1:0]     fill_reg, fill_next;
    wphase_t           write_phase_reg, write_phase_next;
    status_t           write_err_reg, write_err_next;
    logic [CW-1:0]     sweep_addr_reg, sweep_addr_next;
    logic [CW-1:0]     sweep_end_reg, sweep_end_next;
    logic [1:0]        sweep_mask_reg, sweep_mask_next;
    logic              m_valid_reg, m_valid_next;
    logic              dac_valid_reg, dac_valid_next;
    status_t           status_reg, status_next;
    logic              block_done_reg, block_done_next;
    logic              underrun_reg, underrun_next;
    logic              request_reg, request_next;

    logic              in_acc;
    logic [1:0]        wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CODE_BITS-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [CODE_BITS-1:0] rd_data;
    logic [CODE_BITS-1:0] pcm_code;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign in_acc    = s_valid && s_ready;
    assign pcm_code  = {~s_pcm_sample[PCM_W-1], s_pcm_sample[PCM_W-2:PCM_W-CODE_BITS]};

    always_comb begin
        eff_next    = eff_reg;
        notify_next = notify_reg;
        if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_BLOCK_SAMPLES: begin
                    if (cfg_data == '0) begin
                        eff_next = CW'(1);
                    end else if (32'(cfg_data) > MAX_BLOCK_SAMPLES) begin
                        eff_next = CW'(MAX_BLOCK_SAMPLES);
                    end else begin
                        eff_next = CW'(cfg_data);
                    end
                end
                REG_NOTIFY_ENABLE: begin
                    notify_next = cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        logic [CW-1:0] pos_inc;
        logic [CW-1:0] fill_inc;
        wphase_t       wp;
        logic [CW-1:0] fp;
        logic          hf;
        status_t       we;

        state_next       = state_reg;
        active_half_next = active_half_reg;
        running_next     = running_reg;
        half_free_next   = half_free_reg;
        half_ready_next  = half_ready_reg;
        play_pos_next    = play_pos_reg;
        fill_next        = fill_reg;
        write_phase_next = write_phase_reg;
        write_err_next   = write_err_reg;
        sweep_addr_next  = sweep_addr_reg;
        sweep_end_next   = sweep_end_reg;
        sweep_mask_next  = sweep_mask_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        dac_valid_next   = dac_valid_reg;
        status_next      = status_reg;
        block_done_next  = block_done_reg;
        underrun_next    = underrun_reg;
        request_next     = request_reg;
        wr_en            = 2'b00;
        wr_addr          = sweep_addr_reg[AW-1:0];
        wr_data          = SILENCE;
        rd_en            = 1'b0;
        rd_addr          = play_pos_reg;
        pos_inc          = CW'(play_pos_reg) + CW'(1);
        fill_inc         = fill_reg + CW'(1);
        wp               = write_phase_reg;
        fp               = fill_reg;
        hf               = half_free_reg;
        we               = write_err_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    m_valid_next    = 1'b1;
                    dac_valid_next  = 1'b0;
                    status_next     = ST_OK;
                    block_done_next = 1'b0;
                    underrun_next   = 1'b0;
                    request_next    = 1'b0;
                    case (mode_t'(s_mode))
                        MODE_START: begin
                            if (!running_reg) begin
                                sweep_addr_next  = '0;
                                sweep_end_next   = eff_reg;
                                sweep_mask_next  = 2'b11;
                                state_next       = S_FILL;
                                active_half_next = 1'b0;
                                play_pos_next    = '0;
                                half_free_next   = 1'b1;
                                half_ready_next  = 1'b0;
                                running_next     = 1'b1;
                                request_next     = notify_reg;
                            end
                        end
                        MODE_STOP, MODE_FAULT: begin
                            running_next    = 1'b0;
                            half_free_next  = 1'b0;
                            half_ready_next = 1'b0;
                        end
                        MODE_WRITE: begin
                            if (wp == WP_IDLE) begin
                                if (!running_reg) begin
                                    we = ST_NOT_STARTED;
                                    wp = WP_DISCARD;
                                end else if (!hf) begin
                                    we = ST_NO_BUFFER;
                                    wp = WP_DISCARD;
                                end else begin
                                    hf = 1'b0;
                                    fp = '0;
                                    wp = WP_WRITING;
                                end
                            end
                            if (wp == WP_WRITING) begin
                                if (fp >= eff_reg) begin
                                    if (running_reg) begin
                                        hf = 1'b1;
                                    end
                                    we = ST_TOO_LONG;
                                    wp = WP_DISCARD;
                                end else begin
                                    wr_en    = active_half_reg ? 2'b01 : 2'b10;
                                    wr_addr  = fp[AW-1:0];
                                    wr_data  = pcm_code;
                                    fill_inc = fp + CW'(1);
                                    fp       = fill_inc;
                                    if (s_last_sample) begin
                                        if (fill_inc < eff_reg) begin
                                            sweep_addr_next = fill_inc;
                                            sweep_end_next  = eff_reg;
                                            sweep_mask_next = wr_en;
                                            state_next      = S_FILL;
                                        end
                                        if (running_reg) begin
                                            half_ready_next = 1'b1;
                                        end
                                        fp = '0;
                                        wp = WP_IDLE;
                                    end
                                end
                            end
                            if (wp == WP_DISCARD) begin
                                status_next = we;
                                if (s_last_sample) begin
                                    wp = WP_IDLE;
                                end
                            end
                            write_phase_next = wp;
                            fill_next        = fp;
                            half_free_next   = hf;
                            write_err_next   = we;
                        end
                        MODE_TICK: begin
                            if (running_reg) begin
                                rd_en          = 1'b1;
                                dac_valid_next = 1'b1;
                                m_valid_next   = 1'b0;
                                state_next     = S_READ;
                                if (pos_inc >= eff_reg) begin
                                    play_pos_next   = '0;
                                    block_done_next = 1'b1;
                                    if (half_ready_reg) begin
                                        active_half_next = ~active_half_reg;
                                        half_ready_next  = 1'b0;
                                        half_free_next   = 1'b1;
                                        request_next     = notify_reg;
                                    end else begin
                                        underrun_next = 1'b1;
                                        request_next  = notify_reg && half_free_reg;
                                    end
                                end else begin
                                    play_pos_next = pos_inc[AW-1:0];
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end
            S_FILL: begin
                wr_en           = sweep_mask_reg;
                sweep_addr_next = sweep_addr_reg + CW'(1);
                if (sweep_addr_next == sweep_end_reg) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            eff_reg         <= CW'(EFF_RST);
            notify_reg      <= 1'b0;
            active_half_reg <= 1'b0;
            running_reg     <= 1'b0;
            half_free_reg   <= 1'b0;
            half_ready_reg  <= 1'b0;
            play_pos_reg    <= '0;
            fill_reg        <= '0;
            write_phase_reg <= WP_IDLE;
            write_err_reg   <= ST_OK;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            eff_reg         <= eff_next;
            notify_reg      <= notify_next;
            active_half_reg <= active_half_next;
            running_reg     <= running_next;
            half_free_reg   <= half_free_next;
            half_ready_reg  <= half_ready_next;
            play_pos_reg    <= play_pos_next;
            fill_reg        <= fill_next;
            write_phase_reg <= write_phase_next;
            write_err_reg   <= write_err_next;
            m_valid_reg     <= m_valid_next;
        end
        sweep_addr_reg <= sweep_addr_next;
        sweep_end_reg  <= sweep_end_next;
        sweep_mask_reg <= sweep_mask_next;
        dac_valid_reg  <= dac_valid_next;
        status_reg     <= status_next;
        block_done_reg <= block_done_next;
        underrun_reg   <= underrun_next;
        request_reg    <= request_next;
    end

    pdsf_sample_store #(
        .DEPTH  (MAX_BLOCK_SAMPLES),
        .DATA_W (CODE_BITS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_half (active_half_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_valid         = m_valid_reg;
    assign m_dac_valid     = dac_valid_reg;
    assign m_dac_code      = dac_valid_reg ? rd_data : '0;
    assign m_status        = status_reg;
    assign m_block_done    = block_done_reg;
    assign m_underrun      = underrun_reg;
    assign m_request_block = request_reg;

    `ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid_reg && !m_ready, m_valid_reg, "result dropped before it was taken")
    `ASSERT_IMPL(a_ready_needs_run, aclk, aresetn, half_ready_reg, running_reg, "ready half while stopped")
    `ASSERT_IMPL(a_read_slot_free, aclk, aresetn, state_reg == S_READ, !m_valid_reg, "result slot busy at read")
    `ASSERT_NEXT(a_tick_reads, aclk, aresetn, in_acc && (s_mode == MODE_TICK) && running_reg, state_reg == S_READ, "tick did not read")
    `ASSERT_IMPL(a_fill_in_range, aclk, aresetn, state_reg == S_FILL, sweep_addr_reg < sweep_end_reg, "fill sweep out of range")

endmodule

@@ verif/pingpong_dac_sample_feeder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ping-pong DAC sample feeder testbench
// Drives start, stop, fault, sample write and tick requests into the feeder
// through a queue-fed driver. A clocked monitor checks every result against
// a behavioural predictor of the double buffer. The run passes through
// several block sizes and notification settings, with a short directed
// opening, random traffic, random idling on both sides and one long result
// stall.
// ----------------------------------------------------------------------------
module pingpong_dac_sample_feeder_test;

    import pdsf_pkg::*;

    localparam int MAX_BLOCK      = 512;
    localparam int CODE_BITS      = 12;
    localparam logic [CODE_BITS-1:0] SILENCE = 12'h800;
    localparam int PHASE_COUNT    = 10;
    localparam int PRESSURE_PHASE = 8;
    localparam int CYCLE_LIMIT    = 1000000;

    typedef struct packed {
        mode_t             mode;
        logic signed [15:0] pcm;
        logic              last;
    } feed_item_t;

    typedef struct packed {
        logic                 dac_valid;
        logic [CODE_BITS-1:0] dac_code;
        status_t              status;
        logic                 block_done;
        logic                 underrun;
        logic                 request_block;
    } feeder_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [BLOCK_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [MODE_W-1:0] s_mode = '0;
    logic signed [PCM_W-1:0] s_pcm_sample = '0;
    logic s_last_sample = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_dac_valid;
    logic [CODE_BITS-1:0] m_dac_code;
    logic [STATUS_W-1:0] m_status;
    logic m_block_done;
    logic m_underrun;
    logic m_request_block;

    feed_item_t     command_queue[$];
    feeder_result_t pending_outcomes[$];
    int items_queued = 0;
    int results_seen = 0;
    int error_count = 0;
    int cycle_count = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    logic hold_armed = 1'b0;
    logic hold_used = 1'b0;
    int hold_left = 0;

    // Shadow state of the double buffer.
    logic [CODE_BITS-1:0] shadow_store [0:2*MAX_BLOCK-1];
    logic    cur_half = 1'b0;
    logic    is_running = 1'b0;
    logic    free_half = 1'b0;
    logic    ready_half = 1'b0;
    int      play_pos = 0;
    int      fill_pos = 0;
    wphase_t wphase = WP_IDLE;
    status_t werror = ST_OK;
    logic [BLOCK_W-1:0] blk_samples = 10'd512;
    logic    notify = 1'b0;

    pingpong_dac_sample_feeder dut (.*);

    always #2 aclk = ~aclk;

    function automatic int effective_block();
        if (blk_samples == 0) return 1;
        if (blk_samples > MAX_BLOCK) return MAX_BLOCK;
        return blk_samples;
    endfunction

    function automatic logic [CODE_BITS-1:0] offset_code(logic [15:0] pcm);
        logic [15:0] flipped;
        flipped = pcm ^ 16'h8000;
        return flipped[15 -: CODE_BITS];
    endfunction

    task automatic pad_with_silence(int half, int from, int upto);
        for (int i = from; i < upto && i < MAX_BLOCK; i++) begin
            shadow_store[half * MAX_BLOCK + i] = SILENCE;
        end
    endtask

    task automatic advance_feeder(mode_t mode, logic [15:0] pcm, logic last);
        feeder_result_t r;
        int eff;
        int idle;
        r = '0;
        r.status = ST_OK;
        eff = effective_block();
        case (mode)
            MODE_START: begin
                if (!is_running) begin
                    pad_with_silence(0, 0, eff);
                    pad_with_silence(1, 0, eff);
                    cur_half = 1'b0;
                    play_pos = 0;
                    free_half = 1'b1;
                    ready_half = 1'b0;
                    is_running = 1'b1;
                    r.request_block = notify;
                end
            end
            MODE_STOP, MODE_FAULT: begin
                if (is_running) begin
                    is_running = 1'b0;
                    free_half = 1'b0;
                    ready_half = 1'b0;
                end
            end
            MODE_WRITE: begin
                if (wphase == WP_IDLE) begin
                    if (!is_running) begin
                        werror = ST_NOT_STARTED;
                        wphase = WP_DISCARD;
                    end else if (!free_half) begin
                        werror = ST_NO_BUFFER;
                        wphase = WP_DISCARD;
                    end else begin
                        free_half = 1'b0;
                        fill_pos = 0;
                        wphase = WP_WRITING;
                    end
                end
                if (wphase == WP_WRITING) begin
                    if (fill_pos >= eff) begin
                        if (is_running) free_half = 1'b1;
                        werror = ST_TOO_LONG;
                        wphase = WP_DISCARD;
                    end else begin
                        idle = int'(cur_half ^ 1'b1);
                        shadow_store[idle * MAX_BLOCK + fill_pos] = offset_code(pcm);
                        fill_pos++;
                        if (last) begin
                            pad_with_silence(idle, fill_pos, eff);
                            if (is_running) ready_half = 1'b1;
                            fill_pos = 0;
                            wphase = WP_IDLE;
                        end
                    end
                end
                if (wphase == WP_DISCARD) begin
                    r.status = werror;
                    if (last) wphase = WP_IDLE;
                end
            end
            MODE_TICK: begin
                if (is_running) begin
                    if (play_pos >= MAX_BLOCK) play_pos = 0;
                    r.dac_code = shadow_store[int'(cur_half) * MAX_BLOCK + play_pos];
                    r.dac_valid = 1'b1;
                    play_pos++;
                    if (play_pos >= eff) begin
                        play_pos = 0;
                        r.block_done = 1'b1;
                        if (ready_half) begin
                            cur_half = ~cur_half;
                            ready_half = 1'b0;
                            free_half = 1'b1;
                        end else begin
                            r.underrun = 1'b1;
                        end
                        r.request_block = notify && free_half;
                    end
                end
            end
            default: ;
        endcase
        pending_outcomes.push_back(r);
    endtask

    task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
        error_count++;
        if (error_count <= 10) begin
            $display("Mismatch on %s of result %0d: expected %h, got %h",
                     what, results_seen, want, got);
        end
    endtask

    task automatic push_item(mode_t mode, logic [15:0] pcm, logic last);
        command_queue.push_back('{mode, pcm, last});
        items_queued++;
    endtask

    function automatic logic [15:0] random_pcm();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        return 16'($urandom);
    endfunction

    task automatic write_register(reg_index_t idx, logic [BLOCK_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_BLOCK_SAMPLES) blk_samples = value;
        else notify = value[0];
    endtask

    task automatic queue_opening_requests();
        push_item(MODE_TICK, 16'h0000, 1'b0);
        push_item(MODE_STOP, 16'h0000, 1'b0);
        push_item(MODE_FAULT, 16'h0000, 1'b0);
        push_item(MODE_WRITE, 16'h8000, 1'b0);
        push_item(MODE_WRITE, 16'h7FFF, 1'b1);
        push_item(MODE_START, 16'h0000, 1'b0);
        push_item(MODE_START, 16'hFFFF, 1'b1);
        push_item(MODE_WRITE, 16'h8000, 1'b0);
        push_item(MODE_WRITE, 16'h7FFF, 1'b1);
        push_item(MODE_WRITE, 16'h0000, 1'b1);
        repeat (8) push_item(MODE_TICK, 16'h0000, 1'b0);
        push_item(MODE_WRITE, 16'h0000, 1'b0);
        push_item(MODE_WRITE, 16'hFFFF, 1'b0);
        push_item(MODE_WRITE, 16'h0001, 1'b0);
        push_item(MODE_WRITE, 16'h0010, 1'b0);
        push_item(MODE_WRITE, 16'h000F, 1'b0);
        push_item(MODE_WRITE, 16'h0005, 1'b1);
        push_item(MODE_FAULT, 16'h0000, 1'b0);
    endtask

    task automatic compose_traffic(int eff, int budget);
        int first;
        int pick;
        int k;
        int len;
        int full_pct;
        int long_pct;
        first = items_queued;
        full_pct = (eff > 64) ? 5 : 20;
        long_pct = (eff > 64) ? 3 : 15;
        push_item(MODE_START, 16'h0000, 1'b0);
        while (items_queued - first < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                k = $urandom_range(0, 99);
                if (k < long_pct) len = eff + $urandom_range(1, 3);
                else if (k < long_pct + full_pct) len = eff;
                else len = $urandom_range(1, (eff < 24) ? eff : 24);
                for (int n = 1; n <= len; n++) push_item(MODE_WRITE, random_pcm(), n == len);
            end else if (pick < 82) begin
                if ($urandom_range(0, 5) == 0) len = eff + 1;
                else len = $urandom_range(1, (2 * eff + 1 < 40) ? 2 * eff + 1 : 40);
                repeat (len) push_item(MODE_TICK, random_pcm(), 1'($urandom_range(0, 1)));
            end else if (pick < 87) begin
                push_item(MODE_START, random_pcm(), 1'($urandom_range(0, 1)));
            end else if (pick < 91) begin
                push_item(MODE_STOP, random_pcm(), 1'($urandom_range(0, 1)));
            end else if (pick < 94) begin
                push_item(MODE_FAULT, random_pcm(), 1'($urandom_range(0, 1)));
            end else begin
                push_item(mode_t'($urandom_range(0, 4)), random_pcm(),
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    always @(posedge aclk) begin : sender
        feed_item_t offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_feeder(mode_t'(s_mode), s_pcm_sample, s_last_sample);
            end
            if (!s_valid || s_ready) begin
                if (command_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    offer = command_queue.pop_front();
                    s_valid <= 1'b1;
                    s_mode <= offer.mode;
                    s_pcm_sample <= offer.pcm;
                    s_last_sample <= offer.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : long_hold
        if (!aresetn) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_armed && !hold_used) begin
            hold_left <= 300;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin : receiver
        feeder_result_t seen;
        feeder_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                seen = '{m_dac_valid, m_dac_code, status_t'(m_status),
                         m_block_done, m_underrun, m_request_block};
                if (pending_outcomes.size() == 0) begin
                    note_mismatch("unexpected result code", 16'h0, 16'(seen.dac_code));
                end else begin
                    want = pending_outcomes.pop_front();
                    if (seen.dac_valid !== want.dac_valid)
                        note_mismatch("dac_valid", 16'(want.dac_valid), 16'(seen.dac_valid));
                    if (seen.dac_code !== want.dac_code)
                        note_mismatch("dac_code", 16'(want.dac_code), 16'(seen.dac_code));
                    if (seen.status !== want.status)
                        note_mismatch("status", 16'(want.status), 16'(seen.status));
                    if (seen.block_done !== want.block_done)
                        note_mismatch("block_done", 16'(want.block_done), 16'(seen.block_done));
                    if (seen.underrun !== want.underrun)
                        note_mismatch("underrun", 16'(want.underrun), 16'(seen.underrun));
                    if (seen.request_block !== want.request_block)
                        note_mismatch("request_block", 16'(want.request_block),
                                      16'(seen.request_block));
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int block_plan [PHASE_COUNT];
        int notify_plan [PHASE_COUNT];
        int budget_plan [PHASE_COUNT];
        block_plan  = '{4, 1, 7, 512, 3, 16, 0, 1023, 12, 5};
        notify_plan = '{1, 1, 0, 1, 1, 0, 1, 0, 1, 1};
        budget_plan = '{0, 150, 200, 150, 150, 200, 100, 50, 200, 150};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase < 4) begin
                sender_idle_pct = 38;
                receiver_idle_pct = 68;
            end else if (phase < 7) begin
                sender_idle_pct = 68;
                receiver_idle_pct = 38;
            end else begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            @(posedge aclk);
            write_register(REG_BLOCK_SAMPLES, BLOCK_W'(block_plan[phase]));
            write_register(REG_NOTIFY_ENABLE, BLOCK_W'(notify_plan[phase]));
            @(negedge aclk);
            if (phase == 0) queue_opening_requests();
            else compose_traffic(effective_block(), budget_plan[phase]);
            // Leave the feeder stopped so that the next block size takes effect on a fresh start.
            push_item(MODE_STOP, 16'h0000, 1'b0);
            if (phase == PRESSURE_PHASE) hold_armed = 1'b1;
            do begin
                @(negedge aclk);
            end while (command_queue.size() != 0 || s_valid || pending_outcomes.size() != 0);
            repeat (32) @(posedge aclk);
        end
        if (error_count == 0 && pending_outcomes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/pdsf_pkg.sv
rtl/core/pdsf_sample_store.sv
rtl/core/pingpong_dac_sample_feeder.sv
verif/pingpong_dac_sample_feeder_test.sv
